>>> design/i6otw_pkg.sv
// Shared types and constants for the IPv6 option TLV walker.
// Used by i6otw_outq and ipv6_option_tlv_walker; depends on nothing.
`default_nettype none

package i6otw_pkg;

    // Field widths of the byte and report channels
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int OFFSET_W = 11;

    // Default header size limit
    localparam int MAX_HEADER_BYTES_DEF = 2048;

    // Report kinds
    localparam logic [KIND_W-1:0] KIND_OPTION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUNC  = 2'd2;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_SEARCH_MODE = 1'b0;
    localparam logic REG_WANTED_TYPE = 1'b1;

    // Option types with special handling
    localparam logic [BYTE_W-1:0] TYPE_PAD1 = 8'd0;
    localparam logic [BYTE_W-1:0] TYPE_FIRST_REAL = 8'd2;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   opt_type;
        logic [BYTE_W-1:0]   opt_length;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } report_t;

endpackage

`default_nettype wire

>>> design/i6otw_outq.sv
// Four-entry result queue: takes up to two report beats per cycle, gives one per cycle while out_ready is high.
// Depends on i6otw_pkg for the report_t beat type.
`default_nettype none

module i6otw_outq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push0,
    input  wire logic               push1,
    input  wire i6otw_pkg::report_t din0,
    input  wire i6otw_pkg::report_t din1,
    output logic                    room2,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output i6otw_pkg::report_t      dout
);
    import i6otw_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    report_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [CNT_W-1:0]   n_push;

    // Leave room for a byte that yields two beats
    assign room2     = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign dout      = entry_reg[rptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        n_push     = CNT_W'(push0) + CNT_W'(push1);
        wptr_next  = wptr_reg + PTR_W'(n_push);
        rptr_next  = rptr_reg + PTR_W'(pop);
        count_next = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store incoming beats in order
    always_ff @(posedge aclk) begin
        if (push0) begin
            entry_reg[wptr_reg] <= din0;
        end
        if (push1) begin
            entry_reg[wptr_reg + PTR_W'(1)] <= din1;
        end
    end

endmodule

`default_nettype wire

>>> design/ipv6_option_tlv_walker.sv
// Top level of the IPv6 hop-by-hop / destination option TLV walker.
// Depends on i6otw_pkg and instantiates the result queue i6otw_outq.
`default_nettype none

// Takes one header byte per beat and walks the option TLVs after the
// two-byte prefix, one byte per clock while s_ready is high: each accepted
// byte updates the registered walk state and drops its reports (an option
// report, an end report, or both) into a four-entry result queue. Reports
// leave one per cycle while m_ready is high. s_ready is high while the queue
// holds at most two beats, so input keeps flowing while a finished report
// waits on m_ready.
// Registers: search_mode at byte address 0, wanted_type at byte address 4.
module ipv6_option_tlv_walker #(
    parameter int MAX_HEADER_BYTES = i6otw_pkg::MAX_HEADER_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // Byte input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [i6otw_pkg::BYTE_W-1:0]     s_data_byte,
    input  wire logic                             s_end_of_header,
    // Report output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [i6otw_pkg::KIND_W-1:0]          m_report_kind,
    output logic [i6otw_pkg::BYTE_W-1:0]          m_option_type,
    output logic [i6otw_pkg::BYTE_W-1:0]          m_option_length,
    output logic [i6otw_pkg::OFFSET_W-1:0]        m_option_offset,
    output logic                                  m_last_report
);
    import i6otw_pkg::*;

    localparam int POS_W = $clog2(MAX_HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_HEADER_BYTES);

    typedef enum logic [5:0] {
        PH_NEXTHDR = 6'b000001,
        PH_HDRLEN  = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_OVERRUN = 6'b100000
    } phase_t;

    // Configuration registers
    logic              search_mode_reg;
    logic [BYTE_W-1:0] wanted_type_reg;
    logic              cfg_write;

    // Walk state
    phase_t              phase_reg, phase_next, phase_cur;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   left_reg, left_next;
    logic [BYTE_W-1:0]   cur_type_reg, cur_type_next;
    logic [OFFSET_W-1:0] start_reg, start_next;

    logic                s_fire;
    logic                room2;
    logic                trunc;
    logic                emit;
    logic [BYTE_W-1:0]   dec_left;
    logic [OFFSET_W-1:0] idx;
    report_t             opt_rep, end_rep, rep0, rep1, head;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WANTED_TYPE) begin
            prdata = 32'(wanted_type_reg);
        end else begin
            prdata = 32'(search_mode_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_mode_reg <= 1'b0;
            wanted_type_reg <= TYPE_FIRST_REAL;
        end else if (cfg_write) begin
            if (paddr[2] == REG_SEARCH_MODE) begin
                search_mode_reg <= pwdata[0];
            end else begin
                wanted_type_reg <= pwdata[BYTE_W-1:0];
            end
        end
    end

    assign s_ready = room2;
    assign s_fire  = s_valid && s_ready;
    assign idx     = OFFSET_W'(pos_reg);
    assign dec_left = left_reg - BYTE_W'(1);

    // Step the walk by one header byte
    always_comb begin
        phase_cur     = (pos_reg >= POS_MAX) ? PH_OVERRUN : phase_reg;
        phase_next    = phase_cur;
        left_next     = left_reg;
        cur_type_next = cur_type_reg;
        start_next    = start_reg;
        trunc         = 1'b0;
        emit          = 1'b0;
        opt_rep       = '0;
        opt_rep.kind  = KIND_OPTION;
        case (phase_cur)
            PH_NEXTHDR: begin
                phase_next = PH_HDRLEN;
                trunc      = 1'b1;
            end
            PH_HDRLEN: begin
                phase_next = PH_TYPE;
            end
            PH_TYPE: begin
                cur_type_next = s_data_byte;
                start_next    = idx;
                if (s_data_byte == TYPE_PAD1) begin
                    emit = search_mode_reg && (wanted_type_reg == TYPE_PAD1);
                    opt_rep.offset = idx;
                end else begin
                    phase_next = PH_LEN;
                    trunc      = 1'b1;
                end
            end
            PH_LEN: begin
                left_next = s_data_byte;
                emit = (!search_mode_reg && (cur_type_reg >= TYPE_FIRST_REAL)) ||
                       (search_mode_reg && (cur_type_reg == wanted_type_reg));
                opt_rep.opt_type   = cur_type_reg;
                opt_rep.opt_length = s_data_byte;
                opt_rep.offset     = start_reg;
                trunc      = (s_data_byte != '0);
                phase_next = trunc ? PH_DATA : PH_TYPE;
            end
            PH_DATA: begin
                left_next  = dec_left;
                trunc      = (dec_left != '0);
                phase_next = trunc ? PH_DATA : PH_TYPE;
            end
            default: begin
                phase_next = PH_OVERRUN;
                trunc      = 1'b1;
            end
        endcase

        pos_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        // End report; the next byte opens a new header
        end_rep      = '0;
        end_rep.kind = trunc ? KIND_TRUNC : KIND_END;
        end_rep.offset = trunc ? start_next : '0;
        end_rep.last = 1'b1;
        if (s_end_of_header) begin
            phase_next    = PH_NEXTHDR;
            pos_next      = '0;
            left_next     = '0;
            cur_type_next = '0;
            start_next    = '0;
        end

        // Option report goes first when both occur
        opt_rep.last = !s_end_of_header;
        rep0 = emit ? opt_rep : end_rep;
        rep1 = end_rep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_NEXTHDR;
            pos_reg      <= '0;
            left_reg     <= '0;
            cur_type_reg <= '0;
            start_reg    <= '0;
        end else if (s_fire) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            cur_type_reg <= cur_type_next;
            start_reg    <= start_next;
        end
    end

    // Queue reports toward the output channel
    i6otw_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (s_fire && (emit || s_end_of_header)),
        .push1     (s_fire && emit && s_end_of_header),
        .din0      (rep0),
        .din1      (rep1),
        .room2     (room2),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .dout      (head)
    );

    assign m_report_kind   = head.kind;
    assign m_option_type   = head.opt_type;
    assign m_option_length = head.opt_length;
    assign m_option_offset = head.offset;
    assign m_last_report   = head.last;

endmodule

`default_nettype wire
